// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the dispatcher rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ptd_pkg.sv =====
// types and constants of the periodic task dispatcher
// no dependencies; imported by the remainder unit and the core
package ptd_pkg;

   // fixed field widths
   localparam int PERIOD_W    = 16;
   localparam int SLOT_FLD_W  = 8;
   localparam int REQ_TYPE_W  = 3;
   localparam int TASK_SLOT_W = 3;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 8;

   // results per tick and the counter that tracks them
   localparam int MAX_RESULTS = 8;
   localparam int RES_CNT_W   = 4;

   // remainder unit step counter
   localparam int REM_CNT_W   = $clog2(PERIOD_W);

   // request codes carried in tuser
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_TICK    = 3'd0,
      REQ_CREATE  = 3'd1,
      REQ_SUSPEND = 3'd2,
      REQ_RESUME  = 3'd3,
      REQ_DELETE  = 3'd4
   } req_code_type;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_SCAN,
      ST_LOAD,
      ST_DIV,
      ST_PUSH,
      ST_FINAL
   } state_type;

   // status from the remainder unit
   typedef struct packed {
      logic done;
      logic zero;
   } rem_sts_type;

endpackage

// ===== hw/rtl/ptd_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
// no dependencies; holds the per-slot periods of the dispatcher
module ptd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ptd_rem.sv =====
// bit-serial restoring remainder unit, one quotient bit per cycle
// depends on ptd_pkg; used by the core to test whether a period divides the tick count
`include "assert_macros.svh"

module ptd_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptd_pkg::PERIOD_W-1:0]  dividend,
   input  logic [ptd_pkg::PERIOD_W-1:0]  divisor,
   output ptd_pkg::rem_sts_type          sts
);

   import ptd_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [REM_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [PERIOD_W-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_W-1:0]   dsr_ff, dsr_in;
   logic [PERIOD_W:0]     trial;
   logic                  step_last;

   // one shift-and-subtract step per cycle
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dsr_in    = dsr_ff;
      trial     = {rem_ff, dvd_ff[PERIOD_W-1]};
      step_last = (cnt_ff == REM_CNT_W'(PERIOD_W - 1));
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = PERIOD_W'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = trial[PERIOD_W-1:0];
         end
         dvd_in = {dvd_ff[PERIOD_W-2:0], 1'b0};
         cnt_in = REM_CNT_W'(cnt_ff + 1'b1);
         if (step_last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign sts.done = done_ff;
   assign sts.zero = (rem_ff == '0);

   // a finished division leaves the unit free
   `ASSERT_SAME(a_done_not_busy, clock, reset, done_ff, !busy_ff, "remainder done while busy")

endmodule

// ===== hw/rtl/periodic_task_dispatcher_core.sv =====
// periodic task dispatcher: slot table, tick scan and result register
// depends on ptd_pkg, ptd_ram, ptd_rem and assert_macros.svh
`include "assert_macros.svh"

// Usage:
// Requests arrive on the req_ stream; req_tuser holds the request code
// (tick, create, suspend, resume, delete) and req_tdata the slot, period
// and has-code flag. Each request produces one or more response
// transactions on the rsp_ stream, the final one marked by rsp_tlast.
// A create, suspend, resume or delete passes through the command state and
// yields one response with the accepted flag. A tick advances the 16-bit
// tick count and walks the slots from 0 upward: each occupied, resumed slot
// costs a period-memory read and, for a nonzero period, a serial remainder
// of the tick count; each due slot after the first also passes the push
// state. A zero period is skipped after the read, and an unoccupied or
// suspended slot is skipped without one.
// Up to eight due slots are reported, lowest first, or a single
// not-dispatched response if none is due.
// One request is in flight at a time; a new request is taken while the
// last response still sits in the output register. A stalled receiver
// holds the response and pauses the scan at the next response until it drains.
// Reset clears the tick count and all occupied and resumed marks at once;
// the period memory needs no clearing as unoccupied slots are never read.
module periodic_task_dispatcher_core #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // slot[7:0], period[23:8], has_code[24], zero[31:25]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // task_slot[2:0], dispatched[3], accepted[4], zero[7:5]
   output logic        rsp_tlast    // last
);

   import ptd_pkg::*;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      scan_ff, scan_in;
   logic [RES_CNT_W-1:0]   count_ff, count_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [PERIOD_W-1:0]    tick_count_ff, tick_count_in;
   logic [NUM_SLOTS-1:0]   occ_ff, occ_in;
   logic [NUM_SLOTS-1:0]   res_ff, res_in;

   // latched request
   logic [REQ_TYPE_W-1:0]  cmd_ff, cmd_in;
   logic [SLOT_FLD_W-1:0]  slot_ff, slot_in;
   logic [PERIOD_W-1:0]    period_ff, period_in;
   logic                   has_code_ff, has_code_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   emit;
   logic [RSP_TDATA_W-1:0] emit_data;
   logic                   emit_last;
   logic                   advance;
   logic                   scan_last;
   logic                   in_range;
   logic                   acc;
   logic [SLOT_W-1:0]      cmd_idx;
   logic [SLOT_FLD_W-1:0]  pend_wide;

   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [PERIOD_W-1:0]    ram_rd_data;
   logic                   rem_start;
   rem_sts_type            rem_sts;

   // period store, one entry per slot
   ptd_ram #(
      .WIDTH (PERIOD_W),
      .DEPTH (NUM_SLOTS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd_idx),
      .wr_data (period_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   // divisibility test of the tick count by a slot period
   ptd_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (tick_count_ff),
      .divisor  (ram_rd_data),
      .sts      (rem_sts)
   );

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign scan_last = (scan_ff == SLOT_W'(NUM_SLOTS - 1));
   assign in_range  = (slot_ff < SLOT_FLD_W'(NUM_SLOTS));
   assign cmd_idx   = slot_ff[SLOT_W-1:0];
   assign pend_wide = SLOT_FLD_W'(pend_slot_ff);

   // sequencer: next state, table updates and result emission
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      tick_count_in = tick_count_ff;
      occ_in        = occ_ff;
      res_in        = res_ff;
      cmd_in        = cmd_ff;
      slot_in       = slot_ff;
      period_in     = period_ff;
      has_code_in   = has_code_ff;
      req_tready    = 1'b0;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rem_start     = 1'b0;
      emit          = 1'b0;
      emit_data     = '0;
      emit_last     = 1'b0;
      advance       = 1'b0;
      acc           = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in      = req_tuser;
               slot_in     = req_tdata[7:0];
               period_in   = req_tdata[23:8];
               has_code_in = req_tdata[24];
               if (req_tuser == REQ_TICK) begin
                  tick_count_in = PERIOD_W'(tick_count_ff + 1'b1);
                  scan_in       = '0;
                  count_in      = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end

         // single-slot table change, one response
         ST_CMD: begin
            if (out_free) begin
               if (in_range) begin
                  case (cmd_ff)
                     REQ_CREATE: begin
                        if (has_code_ff && !occ_ff[cmd_idx]) begin
                           ram_wr_en       = 1'b1;
                           occ_in[cmd_idx] = 1'b1;
                           res_in[cmd_idx] = 1'b1;
                           acc             = 1'b1;
                        end
                     end
                     REQ_SUSPEND: begin
                        res_in[cmd_idx] = 1'b0;
                        acc             = 1'b1;
                     end
                     REQ_RESUME: begin
                        res_in[cmd_idx] = 1'b1;
                        acc             = 1'b1;
                     end
                     REQ_DELETE: begin
                        occ_in[cmd_idx] = 1'b0;
                        acc             = 1'b1;
                     end
                     default: begin
                        acc = 1'b0;
                     end
                  endcase
               end
               emit      = 1'b1;
               emit_data = {3'b000, acc, 1'b0, 3'b000};
               emit_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         // skip slots that cannot be due, read the period otherwise
         ST_SCAN: begin
            if (occ_ff[scan_ff] && res_ff[scan_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_LOAD;
            end else begin
               advance = 1'b1;
            end
         end

         // a zero period is never due
         ST_LOAD: begin
            if (ram_rd_data != '0) begin
               rem_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               advance = 1'b1;
            end
         end

         // hold back one due slot so the final one can carry last
         ST_DIV: begin
            if (rem_sts.done) begin
               if (rem_sts.zero) begin
                  if (pend_valid_ff) begin
                     state_in = ST_PUSH;
                  end else begin
                     pend_valid_in = 1'b1;
                     pend_slot_in  = scan_ff;
                     count_in      = RES_CNT_W'(count_ff + 1'b1);
                     if (count_ff == RES_CNT_W'(MAX_RESULTS - 1)) begin
                        state_in = ST_FINAL;
                     end else begin
                        advance = 1'b1;
                     end
                  end
               end else begin
                  advance = 1'b1;
               end
            end
         end

         // send the held slot, keep the new one
         ST_PUSH: begin
            if (out_free) begin
               emit         = 1'b1;
               emit_data    = {3'b000, 1'b0, 1'b1, pend_wide[TASK_SLOT_W-1:0]};
               emit_last    = 1'b0;
               pend_slot_in = scan_ff;
               count_in     = RES_CNT_W'(count_ff + 1'b1);
               if (count_ff == RES_CNT_W'(MAX_RESULTS - 1)) begin
                  state_in = ST_FINAL;
               end else begin
                  advance = 1'b1;
               end
            end
         end

         // closing response of a tick
         ST_FINAL: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_last = 1'b1;
               if (pend_valid_ff) begin
                  emit_data = {3'b000, 1'b0, 1'b1, pend_wide[TASK_SLOT_W-1:0]};
               end else begin
                  emit_data = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // step to the next slot or finish the scan
      if (advance) begin
         if (scan_last) begin
            state_in = ST_FINAL;
         end else begin
            scan_in  = SLOT_W'(scan_ff + 1'b1);
            state_in = ST_SCAN;
         end
      end
   end

   // output register next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
         rsp_last_in  = emit_last;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         occ_ff        <= '0;
         res_ff        <= '0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         scan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         occ_ff        <= occ_in;
         res_ff        <= res_in;
         pend_valid_ff <= pend_valid_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      period_ff    <= period_in;
      has_code_ff  <= has_code_in;
      pend_slot_ff <= pend_slot_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= RES_CNT_W'(MAX_RESULTS), "too many results per tick")
   `ASSERT_SAME(a_emit_free, clock, reset, emit, out_free, "response overwrites a waiting response")
   `ASSERT_SAME(a_rem_in_div, clock, reset, rem_sts.done, state_ff == ST_DIV, "remainder finished outside the scan")
   `ASSERT_NEXT(a_tick_adv, clock, reset, req_tvalid && req_tready && req_tuser == REQ_TICK, tick_count_ff == PERIOD_W'($past(tick_count_ff) + 1'b1), "tick count did not advance")

endmodule
